>>> sv/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants for the running min / max / mean statistics
// block.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int SAMPLE_WIDTH = 32;

  localparam logic [31:0] SAMPLE_MASK = 32'((64'(1) << SAMPLE_WIDTH) - 64'(1));
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_RESET   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

>>> sv/rmm_if.sv
// ----------------------------------------------------------------------------
// rmm stream interfaces
// Valid / ready channels for samples in and statistics out.
// ----------------------------------------------------------------------------
interface rmm_smp_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmm_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_count;
  logic [63:0] out_sum;
  logic [31:0] out_mean;
  logic [31:0] out_min;
  logic [31:0] out_max;

  modport source (output valid, output out_count, output out_sum, output out_mean,
                  output out_min, output out_max, input ready);
  modport sink   (input valid, input out_count, input out_sum, input out_mean,
                  input out_min, input out_max, output ready);
endinterface

>>> sv/running_min_max_mean_top.sv
// ----------------------------------------------------------------------------
// running_min_max_mean_top
// Running count, saturating sum, truncated mean, minimum and maximum.
// ----------------------------------------------------------------------------
// One request is taken at a time. After acceptance, a bit-serial pass adds
// the sample into the sum and compares it with the stored minimum and
// maximum, then a radix-2 divider produces one mean bit per cycle, and the
// result is loaded into the output register. The next request is taken the
// cycle after that load, so a new request is never accepted before the
// last result is loaded. A finished result waits in the output register
// while the next request is taken; if it is still unread when the
// following result is ready, that result holds and the input stalls until
// the output register is read. Count and sum saturate; the mean saturates
// at all ones once the quotient no longer fits in 32 bits.
module running_min_max_mean_top (
  input  logic         clk,
  input  logic         rst,
  rmm_smp_if.sink      smp,
  rmm_res_if.source    res
);

  rmm_pkg::state_t state, state_next;

  logic [5:0]  cnt;
  logic        carry;
  logic        lt, gt;
  logic [31:0] s_sh;
  logic [63:0] sum_sh;
  logic [31:0] min_sh, max_sh;
  logic [31:0] count;
  logic [31:0] rem;
  logic [31:0] lo;
  logic        sat;

  logic        out_valid;
  logic [31:0] out_count, out_mean, out_min, out_max;
  logic [63:0] out_sum;

  logic        addend, sbit, carry_next;
  logic [63:0] sum_fin;
  logic [32:0] tmp;
  logic [33:0] diff;
  logic        ge;
  logic        load_out;

  assign addend     = cnt[5] ? 1'b0 : s_sh[0];
  assign sbit       = sum_sh[0] ^ addend ^ carry;
  assign carry_next = (sum_sh[0] & addend) | (sum_sh[0] & carry) | (addend & carry);
  assign sum_fin    = carry_next ? '1 : {sbit, sum_sh[63:1]};

  assign tmp  = {rem, lo[31]};
  assign diff = {1'b0, tmp} - {2'b00, count};
  assign ge   = ~diff[33];

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      rmm_pkg::ST_IDLE: if (smp.valid) state_next = rmm_pkg::ST_ACC;
      rmm_pkg::ST_ACC:  if (cnt == 6'd63) state_next = rmm_pkg::ST_DIV;
      rmm_pkg::ST_DIV:  if (cnt[4:0] == 5'd31) state_next = rmm_pkg::ST_FIN;
      rmm_pkg::ST_FIN: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = rmm_pkg::ST_IDLE;
        end
      end
      default: state_next = rmm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rmm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum_sh    <= '0;
      min_sh    <= rmm_pkg::MIN_RESET;
      max_sh    <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        rmm_pkg::ST_IDLE: begin
          if (smp.valid) begin
            s_sh  <= smp.sample & rmm_pkg::SAMPLE_MASK;
            count <= (count == rmm_pkg::COUNT_MAX) ? count : count + 32'd1;
            carry <= 1'b0;
            lt    <= 1'b0;
            gt    <= 1'b0;
            cnt   <= '0;
          end
        end
        rmm_pkg::ST_ACC: begin
          cnt    <= cnt + 6'd1;
          carry  <= carry_next;
          sum_sh <= (cnt == 6'd63) ? sum_fin : {sbit, sum_sh[63:1]};
          if (!cnt[5]) begin
            s_sh   <= {s_sh[0], s_sh[31:1]};
            min_sh <= {min_sh[0], min_sh[31:1]};
            max_sh <= {max_sh[0], max_sh[31:1]};
            if (s_sh[0] != min_sh[0]) lt <= ~s_sh[0];
            if (s_sh[0] != max_sh[0]) gt <= s_sh[0];
          end
          if (cnt == 6'd63) begin
            rem    <= sum_fin[63:32];
            lo     <= sum_fin[31:0];
            sat    <= sum_fin[63:32] >= count;
            if (lt) min_sh <= s_sh;
            if (gt) max_sh <= s_sh;
          end
        end
        rmm_pkg::ST_DIV: begin
          cnt <= cnt + 6'd1;
          rem <= ge ? diff[31:0] : tmp[31:0];
          lo  <= {lo[30:0], ge};
        end
        rmm_pkg::ST_FIN: cnt <= '0;
        default: cnt <= '0;
      endcase

      if (load_out)       out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count <= count;
      out_sum   <= sum_sh;
      out_mean  <= sat ? '1 : lo;
      out_min   <= min_sh;
      out_max   <= max_sh;
    end
  end

  assign smp.ready     = (state == rmm_pkg::ST_IDLE);
  assign res.valid     = out_valid;
  assign res.out_count = out_count;
  assign res.out_sum   = out_sum;
  assign res.out_mean  = out_mean;
  assign res.out_min   = out_min;
  assign res.out_max   = out_max;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the running count / sum / mean / min / max block.
// Samples go in on a valid/ready channel. A scoreboard class predicts the
// statistics after each accepted request and checks every result in order.
// The bench runs a directed set of extreme samples, then random phases with
// idling on both sides, a long receiver hold-off, a drain pause and a
// stretch with no idling at all.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] count;
  logic [63:0] total;
  logic [31:0] mean;
  logic [31:0] lowest;
  logic [31:0] highest;
} stats_t;

class running_stats_board;
  logic [31:0] count_q;
  logic [63:0] total_q;
  logic [31:0] lowest_q;
  logic [31:0] highest_q;
  stats_t      awaited[$];
  int unsigned errors;

  function new();
    count_q   = '0;
    total_q   = '0;
    lowest_q  = rmm_pkg::MIN_RESET;
    highest_q = '0;
    errors    = 0;
  endfunction

  function stats_t fold_sample(logic [31:0] raw);
    logic [31:0] s;
    logic [63:0] quo;
    stats_t      r;
    s = raw & rmm_pkg::SAMPLE_MASK;
    if (count_q != rmm_pkg::COUNT_MAX) begin
      count_q = count_q + 32'd1;
    end
    if (total_q > (64'hFFFF_FFFF_FFFF_FFFF - {32'd0, s})) begin
      total_q = 64'hFFFF_FFFF_FFFF_FFFF;
    end else begin
      total_q = total_q + {32'd0, s};
    end
    quo = total_q / {32'd0, count_q};
    if (s < lowest_q) begin
      lowest_q = s;
    end
    if (s > highest_q) begin
      highest_q = s;
    end
    r.count   = count_q;
    r.total   = total_q;
    r.mean    = (quo > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    r.lowest  = lowest_q;
    r.highest = highest_q;
    return r;
  endfunction

  function void note_sample(logic [31:0] raw);
    awaited.push_back(fold_sample(raw));
  endfunction

  function void compare(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_stats(stats_t got);
    stats_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: out_count %0d", got.count);
      errors++;
      return;
    end
    want = awaited.pop_front();
    compare("out_count", {32'd0, want.count},   {32'd0, got.count});
    compare("out_sum",   want.total,             got.total);
    compare("out_mean",  {32'd0, want.mean},    {32'd0, got.mean});
    compare("out_min",   {32'd0, want.lowest},  {32'd0, got.lowest});
    compare("out_max",   {32'd0, want.highest}, {32'd0, got.highest});
  endfunction

  function int unsigned outstanding();
    return awaited.size();
  endfunction
endclass

module tb_top;
  localparam int IDLE_PCT   = 25;
  localparam int HOLD_LEN   = 600;
  localparam int TAIL_LEN   = 150;
  localparam int STALL_LIMIT = 10000;

  logic clk;
  logic rst;
  bit   steady;
  bit   hold_req;

  rmm_smp_if smp();
  rmm_res_if res();

  running_stats_board stats_sb;

  running_min_max_mean_top dut (
    .clk (clk),
    .rst (rst),
    .smp (smp.sink),
    .res (res.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(9))
      5: v = $urandom_range(255);
      6: v = 32'hFFFF_FFFF - $urandom_range(255);
      7: v = stats_sb.lowest_q;
      8: v = stats_sb.highest_q;
      9: v = 32'd1 << $urandom_range(31);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [31:0] value, input bit gap_ok);
    while (gap_ok && !steady && $urandom_range(99) < IDLE_PCT) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= value;
    do @(posedge clk); while (!smp.ready);
    stats_sb.note_sample(value);
  endtask

  task automatic send_random(input int n, input bit gap_ok);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(), gap_ok);
    end
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (stats_sb.outstanding() != 0) begin
      @(posedge clk);
    end
  endtask

  // receive side: check accepted results, stall at random or on a hold-off
  initial begin
    int hold_cnt;
    stats_t got;
    hold_cnt = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        got = {res.out_count, res.out_sum, res.out_mean, res.out_min, res.out_max};
        stats_sb.check_stats(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: stop if nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed[] = '{
      32'h0000_1234, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
      32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0002,
      32'h0000_0003, 32'hFFFF_FFFF
    };
    stats_sb = new();
    steady   = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_sample(directed[i], 1'b1);
    end

    send_random(400, 1'b1);

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    send_random(30, 1'b0);

    steady = 1'b1;
    send_random(300, 1'b1);
    steady = 1'b0;

    drain();
    send_random(370, 1'b1);

    drain();
    repeat (TAIL_LEN) @(posedge clk);

    if (stats_sb.errors == 0 && stats_sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
